FILE: sv/ctb_pkg.sv
// ============================================================================
// ctb_pkg : shared types and constants for the countdown timer bank
// holds the bank dimensions, request and result layouts, opcodes, sequencer
// states and the small helper functions used by the sequencer
// ============================================================================
`default_nettype none

package ctb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [NUM_TIMERS-1:0]  timer_vec_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  timer_index;
        logic [31:0] load_value;
    } req_t;

    typedef struct packed {
        logic [3:0] expired_index;
        logic       last_flag;
    } res_t;

    // count memory write port
    typedef struct packed {
        logic   en;
        idx_t   addr;
        count_t data;
    } cnt_wr_t;

    // count memory read port
    typedef struct packed {
        logic en;
        idx_t addr;
    } cnt_rd_t;

    // position of the lowest set bit, zero for an empty mask
    function automatic idx_t lowest_set(input timer_vec_t mask);
        idx_t pos;
        pos = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (mask[i])
            begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

    // true when a request addresses an existing timer
    function automatic logic index_valid(input logic [3:0] t);
        return (int'(t) < NUM_TIMERS);
    endfunction

endpackage

`default_nettype wire

FILE: sv/countdown_timer_bank.sv
// ============================================================================
// countdown_timer_bank : bank of countdown timers
// a request channel carries tick, arm and disarm requests; a result channel
// reports the timers that have run out on each tick
// ============================================================================
// usage
//   request channel : req_valid / req_stall / req_data (opcode, timer_index,
//   load_value); accepted when req_valid is high and req_stall is low
//   result channel  : res_valid / res_stall / res_data (expired_index,
//   last_flag); one result per active timer at zero after a tick, in
//   ascending index order, last_flag set on the final one
//   arm and disarm give no result
//   a tick walks the bank, reading one timer while writing back the one read
//   before, then emits the results; the walk goes through the single
//   registered read port of the count memory feeding the shared decrement
//   unit
//   req_stall stays high for the whole tick, including result emission
//   a stalled receiver holds the result register and pauses emission; the
//   last result of a tick may still wait while the next request is taken
//   reset clears every active flag and the sequencer; counts of timers never
//   armed pass through the walk unused, so the count memory needs no clearing
//   arm or disarm of an index beyond the bank, and the unused opcode, are
//   taken and ignored
// ============================================================================
`default_nettype none

module countdown_timer_bank (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire ctb_pkg::req_t req_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output ctb_pkg::res_t      res_data
);
    import ctb_pkg::*;

    // count memory ports driven by the sequencer
    cnt_wr_t cnt_wr;
    cnt_rd_t cnt_rd;
    count_t  cnt_rd_data;

    // shared decrement unit, fed straight from the registered memory read
    logic    dec_active;
    count_t  dec_count;
    logic    dec_expired;

    ctb_count_mem u_count_mem (
        .clk     (clk),
        .wr      (cnt_wr),
        .rd      (cnt_rd),
        .rd_data (cnt_rd_data)
    );

    ctb_dec_unit u_dec_unit (
        .active    (dec_active),
        .count_in  (cnt_rd_data),
        .count_out (dec_count),
        .expired   (dec_expired)
    );

    // sequencer owns the active flags, the expired mask and the result register
    ctb_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_data    (req_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cnt_wr      (cnt_wr),
        .cnt_rd      (cnt_rd),
        .dec_active  (dec_active),
        .dec_count   (dec_count),
        .dec_expired (dec_expired)
    );

endmodule

`default_nettype wire

FILE: sv/ctb_count_mem.sv
// ============================================================================
// ctb_count_mem : remaining count storage
// one write port and one read port with registered read data
// ============================================================================
`default_nettype none

module ctb_count_mem (
    input  wire logic            clk,
    input  wire ctb_pkg::cnt_wr_t wr,
    input  wire ctb_pkg::cnt_rd_t rd,
    output ctb_pkg::count_t       rd_data
);
    import ctb_pkg::*;

    count_t mem [NUM_TIMERS];
    count_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/ctb_dec_unit.sv
// ============================================================================
// ctb_dec_unit : shared decrement and zero compare
// steps one timer count per use and flags a timer that has run out
// ============================================================================
`default_nettype none

module ctb_dec_unit (
    input  wire logic            active,
    input  wire ctb_pkg::count_t count_in,
    output ctb_pkg::count_t      count_out,
    output logic                 expired
);
    import ctb_pkg::*;

    logic nonzero;

    assign nonzero   = (count_in != '0);
    assign count_out = (active && nonzero) ? (count_in - COUNT_WIDTH'(1)) : count_in;
    assign expired   = active && (count_out == '0);

endmodule

`default_nettype wire

FILE: sv/ctb_seq.sv
// ============================================================================
// ctb_seq : timer bank sequencer
// handles arm and disarm requests, walks the count memory on a tick and
// emits one result per expired timer from an output register
// ============================================================================
`default_nettype none

module ctb_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire ctb_pkg::req_t    req_data,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output ctb_pkg::res_t         res_data,
    output ctb_pkg::cnt_wr_t      cnt_wr,
    output ctb_pkg::cnt_rd_t      cnt_rd,
    output logic                  dec_active,
    input  wire ctb_pkg::count_t  dec_count,
    input  wire logic             dec_expired
);
    import ctb_pkg::*;

    state_t     state_reg,   state_next;
    timer_vec_t active_reg,  active_next;
    timer_vec_t expired_reg, expired_next;
    idx_t       rd_idx_reg,  rd_idx_next;
    logic       rd_more_reg, rd_more_next;
    idx_t       wb_idx_reg,  wb_idx_next;
    logic       wb_pend_reg, wb_pend_next;
    logic       res_valid_reg, res_valid_next;
    res_t       res_data_reg,  res_data_next;

    idx_t       req_idx;
    idx_t       emit_idx;
    timer_vec_t emit_rest;
    logic       req_take;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign req_idx   = IDX_W'(req_data.timer_index);
    assign emit_idx  = lowest_set(expired_reg);

    always_comb
    begin
        emit_rest           = expired_reg;
        emit_rest[emit_idx] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            expired_reg   <= '0;
            rd_idx_reg    <= '0;
            rd_more_reg   <= 1'b0;
            wb_idx_reg    <= '0;
            wb_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            expired_reg   <= expired_next;
            rd_idx_reg    <= rd_idx_next;
            rd_more_reg   <= rd_more_next;
            wb_idx_reg    <= wb_idx_next;
            wb_pend_reg   <= wb_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        expired_next   = expired_reg;
        rd_idx_next    = rd_idx_reg;
        rd_more_next   = rd_more_reg;
        wb_idx_next    = wb_idx_reg;
        wb_pend_next   = 1'b0;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        cnt_wr         = '0;
        cnt_rd         = '0;
        dec_active     = active_reg[wb_idx_reg];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req_data.opcode)
                        OP_TICK:
                        begin
                            state_next   = ST_SCAN;
                            expired_next = '0;
                            rd_idx_next  = '0;
                            rd_more_next = 1'b1;
                        end
                        OP_ARM:
                        begin
                            if (index_valid(req_data.timer_index))
                            begin
                                cnt_wr.en            = 1'b1;
                                cnt_wr.addr          = req_idx;
                                cnt_wr.data          = COUNT_WIDTH'(req_data.load_value);
                                active_next[req_idx] = 1'b1;
                            end
                        end
                        OP_DISARM:
                        begin
                            if (index_valid(req_data.timer_index))
                            begin
                                active_next[req_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // read one timer while writing back the one read last cycle
                if (rd_more_reg)
                begin
                    cnt_rd.en    = 1'b1;
                    cnt_rd.addr  = rd_idx_reg;
                    wb_idx_next  = rd_idx_reg;
                    wb_pend_next = 1'b1;
                    if (rd_idx_reg == IDX_W'(NUM_TIMERS - 1))
                    begin
                        rd_more_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end
                if (wb_pend_reg)
                begin
                    cnt_wr.en                = 1'b1;
                    cnt_wr.addr              = wb_idx_reg;
                    cnt_wr.data              = dec_count;
                    expired_next[wb_idx_reg] = dec_expired;
                    if (!rd_more_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (expired_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next              = 1'b1;
                    res_data_next.expired_index = 4'(emit_idx);
                    res_data_next.last_flag     = (emit_rest == '0);
                    expired_next                = emit_rest;
                    if (emit_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

`default_nettype wire
